[hw/rtl/dfaae_pkg.sv]
// Shared types and constants for the DNS first-A-answer extractor.
// Depends on nothing; used by every RTL and checker file of the block.
package dfaae_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT  = 1'd1;

    localparam logic [15:0] EXPECTED_ID_RESET = 16'd0;
    localparam logic [10:0] NAME_LIMIT_RESET  = 11'd256;

    localparam logic [7:0] PTR_MASK      = 8'hC0;
    localparam logic [7:0] MAX_LABEL     = 8'd63;
    localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
    localparam logic [3:0] RR_LAST_IDX   = 4'd9;
    localparam logic [3:0] QFIXED_BYTES  = 4'd4;
    localparam logic [3:0] RDATA_BYTES   = 4'd4;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] CLASS_IN     = 16'd1;
    localparam logic [15:0] RDLEN_A      = 16'd4;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_TRUNC  = 3'd1,
        ST_ID     = 3'd2,
        ST_COUNTS = 3'd3,
        ST_NAME   = 3'd4,
        ST_RECORD = 3'd5
    } status_t;

    typedef enum logic [11:0] {
        PH_HEADER    = 12'b0000_0000_0001,
        PH_QNAME_LEN = 12'b0000_0000_0010,
        PH_QNAME_LAB = 12'b0000_0000_0100,
        PH_QFIXED    = 12'b0000_0000_1000,
        PH_ANAME_1ST = 12'b0000_0001_0000,
        PH_ANAME_PTR = 12'b0000_0010_0000,
        PH_ANAME_LEN = 12'b0000_0100_0000,
        PH_ANAME_LAB = 12'b0000_1000_0000,
        PH_RR_FIXED  = 12'b0001_0000_0000,
        PH_RDATA     = 12'b0010_0000_0000,
        PH_DONE      = 12'b0100_0000_0000,
        PH_FAILED    = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] ip_address;
    } out_t;

    typedef struct packed {
        logic [15:0] expected_id;
        logic [10:0] name_limit;
    } cfg_t;

endpackage

[hw/rtl/dfaae_parse.sv]
// Byte-at-a-time DNS response parser state and its next-state logic.
// Depends on dfaae_pkg; instantiated by dns_first_a_answer_extractor.
module dfaae_parse (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  dfaae_pkg::in_t in_item,
    input  dfaae_pkg::cfg_t cfg,
    output dfaae_pkg::out_t result
);

    typedef struct packed {
        dfaae_pkg::phase_t  phase;
        logic [3:0]         field_byte_count;
        logic [5:0]         label_remaining;
        logic [10:0]        name_length;
        logic [15:0]        captured_field;
        logic [2:0]         header_ok_flags;
        logic [31:0]        address_shift;
        dfaae_pkg::status_t error_code;
    } pstate_t;

    pstate_t st_reg;
    pstate_t st_next;
    pstate_t st_step;

    function automatic pstate_t clear_state();
        pstate_t s;
        s.phase            = dfaae_pkg::PH_HEADER;
        s.field_byte_count = '0;
        s.label_remaining  = '0;
        s.name_length      = '0;
        s.captured_field   = '0;
        s.header_ok_flags  = '0;
        s.address_shift    = '0;
        s.error_code       = dfaae_pkg::ST_OK;
        return s;
    endfunction

    function automatic pstate_t fail_with(pstate_t s, dfaae_pkg::status_t code);
        pstate_t r;
        r            = s;
        r.error_code = code;
        r.phase      = dfaae_pkg::PH_FAILED;
        return r;
    endfunction

    function automatic pstate_t label_len(pstate_t s, logic [7:0] len_byte,
                                          dfaae_pkg::phase_t lab_phase,
                                          dfaae_pkg::phase_t end_phase,
                                          logic [10:0] limit);
        pstate_t     r;
        logic [11:0] sum;
        r   = s;
        sum = {1'b0, s.name_length} + {4'd0, len_byte} + 12'd1;
        if (len_byte == 8'd0) begin
            r.phase            = end_phase;
            r.field_byte_count = '0;
            r.header_ok_flags  = '0;
            r.captured_field   = '0;
        end else if (len_byte > dfaae_pkg::MAX_LABEL) begin
            r = fail_with(s, dfaae_pkg::ST_NAME);
        end else if (sum >= {1'b0, limit}) begin
            r = fail_with(s, dfaae_pkg::ST_NAME);
        end else begin
            r.name_length     = sum[10:0];
            r.label_remaining = len_byte[5:0];
            r.phase           = lab_phase;
        end
        return r;
    endfunction

    logic [7:0]  b;
    logic [15:0] cap_pair;
    logic [5:0]  lab_dec;
    logic [3:0]  cnt_inc;
    logic [2:0]  flags_new;

    assign b        = in_item.data_byte;
    assign cap_pair = {st_reg.captured_field[7:0], b};
    assign cnt_inc  = st_reg.field_byte_count + 4'd1;
    assign lab_dec  = (st_reg.label_remaining != 6'd0) ? st_reg.label_remaining - 6'd1
                                                       : st_reg.label_remaining;

    always_comb begin
        st_step   = st_reg;
        flags_new = st_reg.header_ok_flags;
        case (st_reg.phase)
            dfaae_pkg::PH_HEADER: begin
                case (st_reg.field_byte_count)
                    4'd0, 4'd2, 4'd4, 4'd6: begin
                        st_step.captured_field = {8'd0, b};
                    end
                    4'd1: begin
                        st_step.captured_field = cap_pair;
                        if (cap_pair == cfg.expected_id) flags_new[0] = 1'b1;
                    end
                    4'd5: begin
                        st_step.captured_field = cap_pair;
                        if (cap_pair != 16'd0) flags_new[1] = 1'b1;
                    end
                    4'd7: begin
                        st_step.captured_field = cap_pair;
                        if (cap_pair != 16'd0) flags_new[2] = 1'b1;
                    end
                    default: ;
                endcase
                st_step.header_ok_flags = flags_new;
                if (st_reg.field_byte_count >= dfaae_pkg::HDR_LAST_IDX) begin
                    st_step.field_byte_count = '0;
                    if (!flags_new[0]) begin
                        st_step = fail_with(st_step, dfaae_pkg::ST_ID);
                    end else if (flags_new[2:1] != 2'b11) begin
                        st_step = fail_with(st_step, dfaae_pkg::ST_COUNTS);
                    end else begin
                        st_step.phase       = dfaae_pkg::PH_QNAME_LEN;
                        st_step.name_length = '0;
                    end
                end else begin
                    st_step.field_byte_count = cnt_inc;
                end
            end
            dfaae_pkg::PH_QNAME_LEN: begin
                st_step = label_len(st_reg, b, dfaae_pkg::PH_QNAME_LAB,
                                    dfaae_pkg::PH_QFIXED, cfg.name_limit);
            end
            dfaae_pkg::PH_QNAME_LAB: begin
                st_step.label_remaining = lab_dec;
                if (lab_dec == 6'd0) st_step.phase = dfaae_pkg::PH_QNAME_LEN;
            end
            dfaae_pkg::PH_ANAME_LAB: begin
                st_step.label_remaining = lab_dec;
                if (lab_dec == 6'd0) st_step.phase = dfaae_pkg::PH_ANAME_LEN;
            end
            dfaae_pkg::PH_QFIXED: begin
                st_step.field_byte_count = cnt_inc;
                if (cnt_inc >= dfaae_pkg::QFIXED_BYTES) begin
                    st_step.phase            = dfaae_pkg::PH_ANAME_1ST;
                    st_step.field_byte_count = '0;
                end
            end
            dfaae_pkg::PH_ANAME_1ST: begin
                if (!in_item.last_byte) begin
                    if ((b & dfaae_pkg::PTR_MASK) == dfaae_pkg::PTR_MASK) begin
                        st_step.phase = dfaae_pkg::PH_ANAME_PTR;
                    end else begin
                        st_step.name_length = '0;
                        st_step = label_len(st_step, b, dfaae_pkg::PH_ANAME_LAB,
                                            dfaae_pkg::PH_RR_FIXED, cfg.name_limit);
                    end
                end
            end
            dfaae_pkg::PH_ANAME_PTR: begin
                st_step.phase            = dfaae_pkg::PH_RR_FIXED;
                st_step.field_byte_count = '0;
                st_step.header_ok_flags  = '0;
                st_step.captured_field   = '0;
            end
            dfaae_pkg::PH_ANAME_LEN: begin
                st_step = label_len(st_reg, b, dfaae_pkg::PH_ANAME_LAB,
                                    dfaae_pkg::PH_RR_FIXED, cfg.name_limit);
            end
            dfaae_pkg::PH_RR_FIXED: begin
                if (!st_reg.field_byte_count[0]) begin
                    st_step.captured_field = {8'd0, b};
                end else begin
                    st_step.captured_field = cap_pair;
                    if (st_reg.field_byte_count == 4'd1 && cap_pair != dfaae_pkg::TYPE_A)
                        flags_new[0] = 1'b1;
                    if (st_reg.field_byte_count == 4'd3 && cap_pair != dfaae_pkg::CLASS_IN)
                        flags_new[0] = 1'b1;
                    if (st_reg.field_byte_count == 4'd9 && cap_pair != dfaae_pkg::RDLEN_A)
                        flags_new[0] = 1'b1;
                end
                st_step.header_ok_flags = flags_new;
                if (st_reg.field_byte_count >= dfaae_pkg::RR_LAST_IDX) begin
                    st_step.field_byte_count = '0;
                    if (flags_new != 3'd0) begin
                        st_step = fail_with(st_step, dfaae_pkg::ST_RECORD);
                    end else begin
                        st_step.phase         = dfaae_pkg::PH_RDATA;
                        st_step.address_shift = '0;
                    end
                end else begin
                    st_step.field_byte_count = cnt_inc;
                end
            end
            dfaae_pkg::PH_RDATA: begin
                st_step.address_shift    = {st_reg.address_shift[23:0], b};
                st_step.field_byte_count = cnt_inc;
                if (cnt_inc >= dfaae_pkg::RDATA_BYTES) begin
                    st_step.phase            = dfaae_pkg::PH_DONE;
                    st_step.field_byte_count = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (st_step.phase == dfaae_pkg::PH_DONE) begin
            result.status     = dfaae_pkg::ST_OK;
            result.ip_address = st_step.address_shift;
        end else if (st_step.phase == dfaae_pkg::PH_FAILED) begin
            result.status     = st_step.error_code;
            result.ip_address = '0;
        end else begin
            result.status     = dfaae_pkg::ST_TRUNC;
            result.ip_address = '0;
        end
    end

    always_comb begin
        st_next = st_reg;
        if (step) begin
            st_next = in_item.last_byte ? clear_state() : st_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= clear_state();
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

[hw/rtl/dns_first_a_answer_extractor.sv]
// Top level of the DNS first-A-answer extractor: input register, parser, result register.
// Depends on dfaae_pkg and dfaae_parse.
//
// Takes a DNS response one byte per transfer on s_ (last_byte marks the end) and returns
// one result per packet on m_: a status and the IPv4 address of the first answer. The
// block accepts one byte every clock unless a last byte waits on a held result. A byte
// sits in the input register while the parser advances; a packet's result is registered
// as its last byte leaves that register. The rate is set by the single parser state update
// per byte. A held result stalls the next packet's last byte and the bytes behind it. Write
// expected_id (index 0) and name_limit (index 1) through cfg_ while no packet is in flight.
module dns_first_a_answer_extractor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dfaae_pkg::in_t                   s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dfaae_pkg::out_t                  m_data,
    input  logic                             cfg_we,
    input  logic [dfaae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfaae_pkg::CFG_DATA_W-1:0] cfg_data
);

    dfaae_pkg::cfg_t cfg_reg;
    dfaae_pkg::in_t  in_reg;
    logic            in_valid_reg;
    dfaae_pkg::out_t out_reg;
    logic            out_valid_reg;
    dfaae_pkg::out_t result;
    logic            out_free;
    logic            consume;

    assign out_free = !out_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || consume;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_id <= dfaae_pkg::EXPECTED_ID_RESET;
            cfg_reg.name_limit  <= dfaae_pkg::NAME_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                dfaae_pkg::CFG_EXPECTED_ID: cfg_reg.expected_id <= cfg_data[15:0];
                dfaae_pkg::CFG_NAME_LIMIT:  cfg_reg.name_limit  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    dfaae_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .in_item (in_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_reg.last_byte) begin
            out_reg <= result;
        end
    end

endmodule

[hw/rtl/dfaae_checker.sv]
// Port-level checks for the DNS first-A-answer extractor, bound to its top level.
// Depends on dfaae_pkg and dns_first_a_answer_extractor.
module dfaae_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input dfaae_pkg::out_t m_data
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_addr_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != dfaae_pkg::ST_OK |-> m_data.ip_address == 32'd0)
        else $error("address nonzero on failed status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= dfaae_pkg::ST_RECORD)
        else $error("status code out of range");

endmodule

bind dns_first_a_answer_extractor dfaae_checker u_dfaae_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
